FILE: hw/rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants, types and the small-prime table for the factorial
// divisor counter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

    localparam int NUM_PRIMES = 25;
    localparam int IDX_W      = $clog2(NUM_PRIMES);
    localparam int N_W        = 7;
    localparam int D_W        = 32;
    localparam int EXP_W      = 5;
    localparam int CNT_W      = 56;
    localparam logic [N_W-1:0] MAX_N = 7'd100;

    typedef struct packed {
        logic           start;
        logic [D_W-1:0] dividend;
        logic [N_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [D_W-1:0] quot;
        logic [N_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [N_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
        logic [N_W-1:0] p;
        case (idx)
            5'd0:    p = 7'd2;
            5'd1:    p = 7'd3;
            5'd2:    p = 7'd5;
            5'd3:    p = 7'd7;
            5'd4:    p = 7'd11;
            5'd5:    p = 7'd13;
            5'd6:    p = 7'd17;
            5'd7:    p = 7'd19;
            5'd8:    p = 7'd23;
            5'd9:    p = 7'd29;
            5'd10:   p = 7'd31;
            5'd11:   p = 7'd37;
            5'd12:   p = 7'd41;
            5'd13:   p = 7'd43;
            5'd14:   p = 7'd47;
            5'd15:   p = 7'd53;
            5'd16:   p = 7'd59;
            5'd17:   p = 7'd61;
            5'd18:   p = 7'd67;
            5'd19:   p = 7'd71;
            5'd20:   p = 7'd73;
            5'd21:   p = 7'd79;
            5'd22:   p = 7'd83;
            5'd23:   p = 7'd89;
            5'd24:   p = 7'd97;
            default: p = 7'd127;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fdc_ram.sv
// ----------------------------------------------------------------------------
// fdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fdc_div.sv
// ----------------------------------------------------------------------------
// fdc_div
// Bit-serial restoring divider: 32-bit dividend by a 7-bit prime,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_div
    import fdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(D_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [D_W-1:0]    dvd_reg;
    logic [D_W-1:0]    quot_reg;
    logic [N_W-1:0]    rem_reg;
    logic [N_W-1:0]    dsr_reg;
    logic [N_W:0]      trial;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[D_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(D_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg  <= req.dividend;
            dsr_reg  <= req.divisor;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[D_W-2:0], 1'b0};
            quot_reg <= {quot_reg[D_W-2:0], ge};
            rem_reg  <= ge ? N_W'(trial - {1'b0, dsr_reg}) : trial[N_W-1:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/factorial_divisor_count_by_d.sv
// ----------------------------------------------------------------------------
// factorial_divisor_count_by_d
// Each division runs on the shared bit-serial divider; one request runs
// 25 + (exponents of |d|) + (Legendre terms) divisions. One request is in
// work at a time. The next request enters as soon as the result is in the
// output register, which waits while an earlier result is still unread.
// Reset clears all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module factorial_divisor_count_by_d
    import fdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [N_W-1:0]        n_value,
    input  wire logic signed [D_W-1:0] d_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CNT_W-1:0]           divisor_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_FDIV, S_FWAIT, S_CHK, S_RD, S_LDIV, S_LWAIT, S_MUL, S_OUT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [N_W-1:0]   n_reg;
    logic [D_W-1:0]   m_reg;
    logic [EXP_W-1:0] cnt_reg;
    logic [N_W-1:0]   q_reg;
    logic [N_W-1:0]   e_reg;
    logic [EXP_W-1:0] f_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] res_reg;
    logic             out_valid_reg;
    logic [CNT_W-1:0] out_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic [N_W-1:0]   p;
    logic [D_W-1:0]   d_mag;
    logic [N_W:0]     factor;
    logic [CNT_W+N_W:0] prod;
    logic             ram_we;
    logic             ram_re;
    logic [EXP_W-1:0] ram_rdata;

    assign p      = prime_at(idx_reg);
    assign d_mag  = d_value[D_W-1] ? (D_W'(0) - d_value) : d_value;
    assign factor = {1'b0, e_reg} - {3'b000, f_reg} + 1'b1;
    assign prod   = res_reg * factor;

    assign div_req.start    = (state_reg == S_FDIV) || (state_reg == S_LDIV);
    assign div_req.dividend = (state_reg == S_FDIV) ? m_reg : {{(D_W-N_W){1'b0}}, q_reg};
    assign div_req.divisor  = p;

    assign ram_we = (state_reg == S_FWAIT) && div_rsp.done && (div_rsp.rem != '0);
    assign ram_re = (state_reg == S_RD);

    fdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fdc_ram #(
        .WIDTH (EXP_W),
        .DEPTH (NUM_PRIMES)
    ) u_exp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (cnt_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign divisor_count = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            m_reg         <= '0;
            cnt_reg       <= '0;
            q_reg         <= '0;
            e_reg         <= '0;
            f_reg         <= '0;
            zero_reg      <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg    <= (n_value > MAX_N) ? MAX_N : n_value;
                        m_reg    <= (d_mag == '0) ? D_W'(1) : d_mag;
                        idx_reg  <= '0;
                        cnt_reg  <= '0;
                        zero_reg <= 1'b0;
                        res_reg  <= CNT_W'(1);
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.rem == '0)
                        begin
                            m_reg     <= div_rsp.quot;
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_FDIV;
                        end
                        else
                        begin
                            if (cnt_reg != '0 && p > n_reg)
                            begin
                                zero_reg <= 1'b1;
                            end
                            cnt_reg <= '0;
                            if (idx_reg == IDX_W'(NUM_PRIMES - 1))
                            begin
                                state_reg <= S_CHK;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_FDIV;
                            end
                        end
                    end
                end
                S_CHK:
                begin
                    if (m_reg != D_W'(1))
                    begin
                        zero_reg <= 1'b1;
                    end
                    idx_reg   <= '0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (p > n_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        q_reg     <= n_reg;
                        e_reg     <= '0;
                        state_reg <= S_LDIV;
                    end
                end
                S_LDIV:
                begin
                    f_reg     <= ram_rdata;
                    state_reg <= S_LWAIT;
                end
                S_LWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        e_reg <= e_reg + div_rsp.quot[N_W-1:0];
                        q_reg <= div_rsp.quot[N_W-1:0];
                        if (div_rsp.quot == '0)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_LDIV;
                        end
                    end
                end
                S_MUL:
                begin
                    if ({2'b00, f_reg} > e_reg)
                    begin
                        zero_reg <= 1'b1;
                    end
                    else
                    begin
                        res_reg <= prod[CNT_W-1:0];
                    end
                    if (idx_reg == IDX_W'(NUM_PRIMES - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= zero_reg ? '0 : res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(NUM_PRIMES - 1))
        else $error("prime index out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_FDIV))
        else $error("accepted request did not start factoring");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FWAIT || state_reg == S_LWAIT))
        else $error("division result with no consumer");
`endif

endmodule

`default_nettype wire

FILE: bench/factorial_divisor_count_by_d_checker.sv
// ----------------------------------------------------------------------------
// factorial_divisor_count_by_d_checker
// Watches both channels of the factorial divisor counter, computes the count
// of divisors of n! divisible by |d| for every accepted request and compares
// each returned count with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module factorial_divisor_count_by_d_checker
    import fdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [N_W-1:0]        n_value,
    input  wire logic signed [D_W-1:0] d_value,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [CNT_W-1:0]      divisor_count,
    output int                         errors,
    output int                         outstanding
);

    logic [CNT_W-1:0] count_queue[$];
    int               mismatches = 0;

    function automatic bit is_prime(input int v);
        int k;
        if (v < 2)
            return 0;
        for (k = 2; k * k <= v; k++)
            if (v % k == 0)
                return 0;
        return 1;
    endfunction

    function automatic logic [CNT_W-1:0] count_divisors(input logic [N_W-1:0] nv,
                                                        input logic [D_W-1:0] dv);
        int          nn;
        int          e;
        int          p;
        longint      q;
        logic [31:0] m;
        int          exps[0:100];
        bit          zero;
        logic [63:0] res;
        longint      pk;
        nn = (nv > MAX_N) ? MAX_N : nv;
        m = dv[D_W-1] ? (32'd0 - dv) : dv;
        if (m == 0)
            m = 1;
        zero = 0;
        res = 1;
        foreach (exps[i])
            exps[i] = 0;
        for (q = 2; q * q <= m; q++)
        begin
            while (m % q == 0)
            begin
                m = m / q;
                if (q <= nn)
                    exps[q]++;
                else
                    zero = 1;
            end
        end
        if (m != 1)
        begin
            if (m > nn)
                zero = 1;
            else
                exps[m]++;
        end
        for (p = 2; p <= nn; p++)
        begin
            if (!is_prime(p))
                continue;
            e = 0;
            for (pk = p; pk <= nn; pk = pk * p)
                e += nn / pk;
            if (exps[p] > e)
                zero = 1;
            else
                res = res * (e - exps[p] + 1);
        end
        return zero ? '0 : res[CNT_W-1:0];
    endfunction

    assign outstanding = count_queue.size();
    assign errors      = mismatches;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                count_queue = {count_queue, count_divisors(n_value, d_value)};
            if (out_valid && out_ready)
            begin
                if (count_queue.size() == 0)
                begin
                    $display("%0t: unexpected count %0d", $time, divisor_count);
                    mismatches++;
                end
                else if (count_queue[0] !== divisor_count)
                begin
                    $display("%0t: divisor_count expected %0d actual %0d",
                             $time, count_queue[0], divisor_count);
                    mismatches++;
                    void'(count_queue.pop_front());
                end
                else
                    void'(count_queue.pop_front());
            end
        end
    end

endmodule

`default_nettype wire

FILE: bench/factorial_divisor_count_by_d_test.sv
// ----------------------------------------------------------------------------
// factorial_divisor_count_by_d_test
// Drives directed and random requests into the factorial divisor counter
// through phases of sender gaps and receiver stalls, including a long
// receiver hold-off, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module factorial_divisor_count_by_d_test;
    import fdc_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [N_W-1:0]        n_value;
    logic signed [D_W-1:0] d_value;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CNT_W-1:0]      divisor_count;
    int                    errors;
    int                    outstanding;
    int                    gap_pct;
    int                    stall_pct;
    int                    hold_cycles = 0;
    bit                    hold_armed = 1'b0;
    bit                    hold_done = 1'b0;

    factorial_divisor_count_by_d dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .n_value(n_value), .d_value(d_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .divisor_count(divisor_count)
    );

    factorial_divisor_count_by_d_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .n_value(n_value), .d_value(d_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .divisor_count(divisor_count),
        .errors(errors), .outstanding(outstanding)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 4000000);
        $display("TEST FAILED");
        $finish;
    end

    // hold off once when armed, then stall at random
    always @(posedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            out_ready <= 0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 19999)
                hold_done <= 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(input logic [N_W-1:0] nv, input logic [D_W-1:0] dv);
        int gap;
        if ($urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        n_value <= nv;
        d_value <= dv;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [D_W-1:0] smooth_divisor();
        logic [63:0] acc;
        int          k;
        int          f;
        acc = 1;
        f = $urandom_range(0, 6);
        for (k = 0; k < f; k++)
        begin
            acc = acc * prime_at(IDX_W'($urandom_range(0, NUM_PRIMES - 1)));
            if (acc > 32'h7FFFFFFF)
                return 32'd1 << $urandom_range(0, 30);
        end
        if ($urandom_range(1))
            acc = 0 - acc;
        return acc[D_W-1:0];
    endfunction

    task automatic random_requests(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 75)
                send_request(N_W'($urandom_range(0, 100)), smooth_divisor());
            else
                send_request(N_W'($urandom_range(0, 127)), D_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        n_value = 0;
        d_value = 0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_request(0, 0);
        send_request(1, 1);
        send_request(1, 2);
        send_request(0, -1);
        send_request(100, 0);
        send_request(100, 1);
        send_request(100, 32'h80000000);
        send_request(100, 32'h7FFFFFFF);
        send_request(100, -32'sh7FFFFFFF);
        send_request(127, 97);
        send_request(120, -101);
        send_request(96, 97);
        send_request(97, 97 * 97);
        send_request(10, 3628800);
        send_request(10, -7257600);
        send_request(50, 32'hFFFFFFFF);
        send_request(64, 32'd1 << 30);
        send_request(2, 2);
        send_request(3, 6);
        send_request(100, 2 * 3 * 5 * 7 * 11 * 13 * 17 * 19 * 23);

        random_requests(25);
        gap_pct = 49;
        random_requests(20);
        gap_pct = 0;
        stall_pct = 49;
        random_requests(20);
        gap_pct = 7;
        stall_pct = 7;
        random_requests(20);
        hold_armed <= 1;
        random_requests(15);

        in_valid <= 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4000) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: factorial_divisor_count_by_d.f
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_ram.sv
hw/rtl/fdc_div.sv
hw/rtl/factorial_divisor_count_by_d.sv
bench/factorial_divisor_count_by_d_checker.sv
bench/factorial_divisor_count_by_d_test.sv
